// ===== rtl/fdc_pkg.sv =====
package fdc_pkg;

  localparam int HDR_BYTES = 28;
  localparam int HDR_W     = HDR_BYTES * 8;
  localparam int CNT_W     = 33;

  // header field offsets in bits, little-endian byte order
  localparam int OFS_MAGIC   = 0 * 8;
  localparam int OFS_VERSION = 4 * 8;
  localparam int OFS_KIND    = 6 * 8;
  localparam int OFS_FLAGS   = 8 * 8;
  localparam int OFS_LENGTH  = 12 * 8;
  localparam int OFS_CRC     = 16 * 8;
  localparam int OFS_ID      = 20 * 8;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_DISCARD = 2'd2;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_TRUNCATED   = 3'd1;
  localparam logic [2:0] ST_BAD_MAGIC   = 3'd2;
  localparam logic [2:0] ST_BAD_VERSION = 3'd3;
  localparam logic [2:0] ST_BAD_KIND    = 3'd4;
  localparam logic [2:0] ST_OVERSIZED   = 3'd5;
  localparam logic [2:0] ST_CHECKSUM    = 3'd6;

  localparam logic [15:0] KIND_FIRST = 16'd1;
  localparam logic [15:0] KIND_LAST  = 16'd4;

  localparam logic [1:0] REG_MAX_PAYLOAD = 2'd0;
  localparam logic [1:0] REG_MAGIC       = 2'd1;
  localparam logic [1:0] REG_VERSION     = 2'd2;

  localparam logic [31:0] RST_MAX_PAYLOAD = 32'd65535;
  localparam logic [31:0] RST_MAGIC       = 32'd0;
  localparam logic [15:0] RST_VERSION     = 16'd1;

  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        verdict_valid;
    logic [2:0]  status;
    logic [2:0]  frame_kind;
    logic [15:0] frame_flags;
    logic [63:0] req_tag;
    logic [31:0] payload_length;
    logic [32:0] bytes_consumed;
  } out_item_t;

  typedef struct packed {
    logic [31:0] max_payload_bytes;
    logic [31:0] expected_magic;
    logic [15:0] expected_version;
  } cfg_t;

  // reflected crc-32c, one byte
  function automatic logic [31:0] crc32c_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  // verdict fields from a complete header
  function automatic out_item_t make_verdict(input logic [2:0] st, input logic [HDR_W-1:0] h);
    out_item_t r;
    r = '0;
    r.verdict_valid  = 1'b1;
    r.status         = st;
    r.frame_kind     = (st == ST_OK) ? h[OFS_KIND +: 3] : 3'd0;
    r.frame_flags    = h[OFS_FLAGS +: 16];
    r.req_tag        = h[OFS_ID +: 64];
    r.payload_length = h[OFS_LENGTH +: 32];
    r.bytes_consumed = (st == ST_OK) ?
                       ({1'b0, h[OFS_LENGTH +: 32]} + CNT_W'(HDR_BYTES)) : '0;
    return r;
  endfunction

endpackage

// ===== rtl/frame_deframer_checker_top.sv =====
// Byte-serial frame deframer and checker. One stream byte is taken per cycle
// whenever the result side keeps up; a result left waiting in the result
// register holds up the input. A byte passes through an input register, the
// header/crc logic and a result register before its result is on the ports.
// The rate is set by the one-byte crc-32c update and the header checks, both
// done combinationally between the input and result registers. The 28-byte
// header is gathered in a shift register; the frame's checks run on the last
// header byte. Payload bytes come out as results as they arrive, and each
// frame ends in one verdict; payload of a frame whose verdict is not ok must
// be dropped downstream. After any failure other than truncation, bytes are
// swallowed up to the next end mark. Configuration is to be written through
// the cfg port only while the block is idle; the block does not enforce this.
// cfg_ready is always high. Reset is synchronous and needs no clearing time.
module frame_deframer_checker_top import fdc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_ready,
  input  in_item_t    byte_item,
  output logic        res_valid,
  input  logic        res_ready,
  output out_item_t   res_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t      cfg;
  logic      s1_valid;
  logic      eng_ready;
  in_item_t  s1_item;
  logic      fire;
  logic      has_res;
  out_item_t eng_res;

  assign cfg_ready = 1'b1;
  assign fire      = s1_valid && eng_ready;

  fdc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fdc_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .up_valid (byte_valid),
    .up_ready (byte_ready),
    .up_item  (byte_item),
    .dn_valid (s1_valid),
    .dn_ready (eng_ready),
    .dn_item  (s1_item)
  );

  fdc_engine u_eng (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .fire    (fire),
    .item    (s1_item),
    .has_res (has_res),
    .res     (eng_res)
  );

  fdc_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (fire && has_res),
    .up_ready (eng_ready),
    .up_item  (eng_res),
    .dn_valid (res_valid),
    .dn_ready (res_ready),
    .dn_item  (res_item)
  );

endmodule

// ===== rtl/fdc_cfg_regs.sv =====
module fdc_cfg_regs import fdc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_payload_bytes <= RST_MAX_PAYLOAD;
      cfg.expected_magic    <= RST_MAGIC;
      cfg.expected_version  <= RST_VERSION;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MAX_PAYLOAD: cfg.max_payload_bytes <= cfg_data;
        REG_MAGIC:       cfg.expected_magic    <= cfg_data;
        REG_VERSION:     cfg.expected_version  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/fdc_in_stage.sv =====
module fdc_in_stage import fdc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     up_valid,
  output logic     up_ready,
  input  in_item_t up_item,
  output logic     dn_valid,
  input  logic     dn_ready,
  output in_item_t dn_item
);

  logic valid;

  assign up_ready = !valid || dn_ready;
  assign dn_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_item <= up_item;
    end
  end

endmodule

// ===== rtl/fdc_engine.sv =====
module fdc_engine import fdc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      fire,
  input  in_item_t  item,
  output logic      has_res,
  output out_item_t res
);

  logic [1:0]       phase, phase_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [CNT_W-1:0] frame_end, frame_end_next;
  logic [31:0]      crc, crc_next;
  logic [HDR_W-1:0] hdr, hdr_next;

  logic             in_header;
  logic [4:0]       hcnt;
  logic [CNT_W-1:0] cnt_inc;
  logic [31:0]      crc_upd;
  logic [2:0]       st;
  logic [15:0]      kind;
  logic [31:0]      len;

  assign in_header = (phase != PH_PAYLOAD) && (phase != PH_DISCARD);
  assign hdr_next  = in_header ? {item.in_byte, hdr[HDR_W-1:8]} : hdr;
  // the unused phase code starts a fresh header
  assign hcnt      = (phase == PH_HEADER) ? byte_count[4:0] : 5'd0;
  assign cnt_inc   = byte_count + CNT_W'(1);
  assign crc_upd   = crc32c_byte(crc, item.in_byte);
  assign kind      = hdr_next[OFS_KIND +: 16];
  assign len       = hdr_next[OFS_LENGTH +: 32];

  always_comb begin
    phase_next      = phase;
    byte_count_next = byte_count;
    frame_end_next  = frame_end;
    crc_next        = crc;
    res             = '0;
    has_res         = 1'b0;
    st              = ST_OK;
    unique case (phase)
      PH_DISCARD: begin
        if (item.end_of_input) begin
          phase_next      = PH_HEADER;
          byte_count_next = '0;
          crc_next        = CRC_INIT;
        end
      end
      PH_PAYLOAD: begin
        has_res         = 1'b1;
        crc_next        = crc_upd;
        byte_count_next = cnt_inc;
        if (cnt_inc >= frame_end || item.end_of_input) begin
          if (cnt_inc >= frame_end) begin
            st = ((~crc_upd) == hdr_next[OFS_CRC +: 32]) ? ST_OK : ST_CHECKSUM;
          end else begin
            st = ST_TRUNCATED;
          end
          res             = make_verdict(st, hdr_next);
          byte_count_next = '0;
          crc_next        = CRC_INIT;
          phase_next      = (st == ST_OK || st == ST_TRUNCATED || item.end_of_input) ?
                            PH_HEADER : PH_DISCARD;
        end
        res.payload_valid = 1'b1;
        res.payload_byte  = item.in_byte;
      end
      default: begin
        byte_count_next = CNT_W'(hcnt) + CNT_W'(1);
        phase_next      = PH_HEADER;
        if (hcnt != 5'(HDR_BYTES - 1)) begin
          if (item.end_of_input) begin
            has_res           = 1'b1;
            res.verdict_valid = 1'b1;
            res.status        = ST_TRUNCATED;
            byte_count_next   = '0;
            crc_next          = CRC_INIT;
          end
        end else begin
          if (hdr_next[OFS_MAGIC +: 32] != cfg.expected_magic) begin
            st = ST_BAD_MAGIC;
          end else if (hdr_next[OFS_VERSION +: 16] != cfg.expected_version) begin
            st = ST_BAD_VERSION;
          end else if (kind < KIND_FIRST || kind > KIND_LAST) begin
            st = ST_BAD_KIND;
          end else if (len > cfg.max_payload_bytes) begin
            st = ST_OVERSIZED;
          end else if (len == 32'd0) begin
            // empty payload: crc of nothing is zero
            st = (hdr_next[OFS_CRC +: 32] == 32'd0) ? ST_OK : ST_CHECKSUM;
          end else if (item.end_of_input) begin
            st = ST_TRUNCATED;
          end else begin
            st = ST_OK;
          end
          crc_next = CRC_INIT;
          if (len != 32'd0 && !item.end_of_input && st == ST_OK) begin
            phase_next     = PH_PAYLOAD;
            frame_end_next = {1'b0, len} + CNT_W'(HDR_BYTES);
          end else begin
            has_res         = 1'b1;
            res             = make_verdict(st, hdr_next);
            byte_count_next = '0;
            phase_next      = (st == ST_OK || st == ST_TRUNCATED || item.end_of_input) ?
                              PH_HEADER : PH_DISCARD;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      byte_count <= '0;
      crc        <= CRC_INIT;
    end else if (fire) begin
      phase      <= phase_next;
      byte_count <= byte_count_next;
      crc        <= crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      hdr       <= hdr_next;
      frame_end <= frame_end_next;
    end
  end

endmodule

// ===== rtl/fdc_out_stage.sv =====
module fdc_out_stage import fdc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  output logic      up_ready,
  input  out_item_t up_item,
  output logic      dn_valid,
  input  logic      dn_ready,
  output out_item_t dn_item
);

  logic valid;

  assign up_ready = !valid || dn_ready;
  assign dn_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && up_ready) begin
      dn_item <= up_item;
    end
  end

endmodule

// ===== rtl/fdc_checker.sv =====
module fdc_checker import fdc_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      res_valid,
  input logic      res_ready,
  input out_item_t res_item
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_item))
    else $error("result changed while stalled");

  a_no_verdict_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_item.verdict_valid |->
      res_item.status == ST_OK && res_item.bytes_consumed == '0 &&
      res_item.payload_valid)
    else $error("result without verdict is not a plain payload item");

  a_fail_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.verdict_valid && res_item.status != ST_OK |->
      res_item.frame_kind == 3'd0 && res_item.bytes_consumed == '0)
    else $error("failed verdict carries kind or byte count");

  a_ok_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.verdict_valid && res_item.status == ST_OK |->
      res_item.frame_kind >= 3'd1 && res_item.frame_kind <= 3'd4 &&
      res_item.bytes_consumed == {1'b0, res_item.payload_length} + 33'(HDR_BYTES))
    else $error("ok verdict with wrong kind or byte count");

endmodule

bind frame_deframer_checker_top fdc_checker u_fdc_checker (.*);

// ===== bench/frame_deframer_checker_top_tb.sv =====
module frame_deframer_checker_top_tb;
  import fdc_pkg::*;

  localparam int RESET_CYCLES = 11;
  localparam int STALL_LIMIT  = 2000;
  localparam int SEG_BYTES    = 170;
  localparam int SETTLE       = 6;
  localparam int MAX_REPORTS  = 100;
  localparam int MAX_BODY     = 48;
  localparam int OFS_RESERVED = 10 * 8;
  // end mark position codes for send_frame
  localparam int EOI_NONE     = -1;
  localparam int EOI_LAST     = 1 << 30;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_ready;
  in_item_t    byte_item = '0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  out_item_t   res_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // register shadow
  logic [31:0] max_len    = RST_MAX_PAYLOAD;
  logic [31:0] magic_word = RST_MAGIC;
  logic [15:0] version    = RST_VERSION;

  // deframer state as seen from outside
  logic [1:0]       fr_phase = PH_HEADER;
  logic [CNT_W-1:0] fr_count = '0;
  logic [HDR_W-1:0] hdr_img  = '0;
  logic [31:0]      crc_acc  = CRC_INIT;

  in_item_t  stream_bytes[$];
  out_item_t frame_outputs[$];
  int        queued_total = 0;
  int        mismatches = 0;
  int        stall_cycles = 0;
  int        sender_idle_pct = 34;
  int        receiver_idle_pct = 54;

  frame_deframer_checker_top dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_item   (res_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] crc_update(input logic [31:0] acc, input logic [7:0] d);
    logic [31:0] x;
    int k;
    x = acc ^ {24'd0, d};
    for (k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

  task automatic restart_frame(input logic [1:0] next_phase);
    fr_phase = next_phase;
    fr_count = '0;
    crc_acc  = CRC_INIT;
  endtask

  // expected outputs for one accepted item
  task automatic deframe_byte(input in_item_t it);
    out_item_t   r;
    logic [31:0] len;
    logic [15:0] kind;
    logic [2:0]  st;
    bit          verdict;
    bit          emit;
    r = '0;
    verdict = 1'b0;
    emit = 1'b0;
    st = ST_OK;
    len = hdr_img[OFS_LENGTH +: 32];
    case (fr_phase)
      PH_DISCARD: begin
        if (it.end_of_input) restart_frame(PH_HEADER);
      end
      PH_PAYLOAD: begin
        emit = 1'b1;
        r.payload_valid = 1'b1;
        r.payload_byte = it.in_byte;
        crc_acc = crc_update(crc_acc, it.in_byte);
        fr_count = fr_count + CNT_W'(1);
        if (fr_count >= {1'b0, len} + CNT_W'(HDR_BYTES)) begin
          verdict = 1'b1;
          st = (~crc_acc == hdr_img[OFS_CRC +: 32]) ? ST_OK : ST_CHECKSUM;
        end else if (it.end_of_input) begin
          verdict = 1'b1;
          st = ST_TRUNCATED;
        end
      end
      default: begin
        if (fr_phase != PH_HEADER) restart_frame(PH_HEADER);
        hdr_img[8 * fr_count[4:0] +: 8] = it.in_byte;
        fr_count = fr_count + CNT_W'(1);
        if (fr_count < HDR_BYTES) begin
          if (it.end_of_input) begin
            // short header: only the status is reported
            emit = 1'b1;
            r.verdict_valid = 1'b1;
            r.status = ST_TRUNCATED;
            restart_frame(PH_HEADER);
          end
        end else begin
          len = hdr_img[OFS_LENGTH +: 32];
          kind = hdr_img[OFS_KIND +: 16];
          verdict = 1'b1;
          if (hdr_img[OFS_MAGIC +: 32] != magic_word) st = ST_BAD_MAGIC;
          else if (hdr_img[OFS_VERSION +: 16] != version) st = ST_BAD_VERSION;
          else if (kind < KIND_FIRST || kind > KIND_LAST) st = ST_BAD_KIND;
          else if (len > max_len) st = ST_OVERSIZED;
          else if (len == 0) st = (hdr_img[OFS_CRC +: 32] == 0) ? ST_OK : ST_CHECKSUM;
          else if (it.end_of_input) st = ST_TRUNCATED;
          else begin
            verdict = 1'b0;
            fr_phase = PH_PAYLOAD;
            crc_acc = CRC_INIT;
          end
        end
      end
    endcase
    if (verdict) begin
      emit = 1'b1;
      r.verdict_valid  = 1'b1;
      r.status         = st;
      r.frame_kind     = (st == ST_OK) ? hdr_img[OFS_KIND +: 3] : 3'd0;
      r.frame_flags    = hdr_img[OFS_FLAGS +: 16];
      r.req_tag        = hdr_img[OFS_ID +: 64];
      r.payload_length = len;
      r.bytes_consumed = (st == ST_OK) ? {1'b0, len} + CNT_W'(HDR_BYTES) : '0;
      if (st == ST_OK || st == ST_TRUNCATED || it.end_of_input) restart_frame(PH_HEADER);
      else restart_frame(PH_DISCARD);
    end
    if (emit) frame_outputs.insert(frame_outputs.size(), r);
  endtask

  task automatic check_field(input string fname, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
    end
  endtask

  task automatic compare_result(input out_item_t got);
    out_item_t want;
    if (frame_outputs.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: unexpected result, expected none, actual %0h", $time, got);
    end else begin
      want = frame_outputs.pop_front();
      check_field("payload_valid", want.payload_valid, got.payload_valid);
      check_field("payload_byte", want.payload_byte, got.payload_byte);
      check_field("verdict_valid", want.verdict_valid, got.verdict_valid);
      check_field("status", want.status, got.status);
      check_field("frame_kind", want.frame_kind, got.frame_kind);
      check_field("frame_flags", want.frame_flags, got.frame_flags);
      check_field("req_tag", want.req_tag, got.req_tag);
      check_field("payload_length", want.payload_length, got.payload_length);
      check_field("bytes_consumed", want.bytes_consumed, got.bytes_consumed);
    end
  endtask

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      if (byte_valid && byte_ready) deframe_byte(byte_item);
      if (!byte_valid || byte_ready) begin
        if (stream_bytes.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          byte_valid <= 1'b1;
          byte_item <= stream_bytes.pop_front();
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) compare_result(res_item);
      res_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_valid && byte_ready) || (res_valid && res_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic queue_byte(input logic [7:0] b, input bit eoi);
    in_item_t it;
    it.in_byte = b;
    it.end_of_input = eoi;
    stream_bytes.insert(stream_bytes.size(), it);
    queued_total++;
  endtask

  // header, npay payload bytes, extra trailing bytes; cut after the end mark
  task automatic send_frame(input logic [31:0] magic, input logic [15:0] ver,
                            input logic [15:0] kind, input logic [31:0] len,
                            input int npay, input bit crc_good, input int extra,
                            input int eoi_at);
    logic [HDR_W-1:0] h;
    logic [7:0]       body[$];
    logic [7:0]       b;
    logic [31:0]      c;
    int               i;
    int               total;
    int               last;
    body = {};
    c = CRC_INIT;
    for (i = 0; i < npay; i++) begin
      b = $urandom;
      body.insert(body.size(), b);
      c = crc_update(c, b);
    end
    c = ~c;
    if (!crc_good) c = c ^ $urandom_range(1, 32'hFFFF_FFFF);
    for (i = 0; i < extra; i++) begin
      b = $urandom;
      body.insert(body.size(), b);
    end
    h = '0;
    h[OFS_MAGIC +: 32]    = magic;
    h[OFS_VERSION +: 16]  = ver;
    h[OFS_KIND +: 16]     = kind;
    h[OFS_FLAGS +: 16]    = $urandom;
    h[OFS_RESERVED +: 16] = $urandom;
    h[OFS_LENGTH +: 32]   = len;
    h[OFS_CRC +: 32]      = c;
    h[OFS_ID +: 64]       = {$urandom, $urandom};
    total = HDR_BYTES + body.size();
    last = (eoi_at >= 0 && eoi_at < total) ? eoi_at : total - 1;
    for (i = 0; i <= last; i++) begin
      b = (i < HDR_BYTES) ? h[8 * i +: 8] : body[i - HDR_BYTES];
      queue_byte(b, i == last && eoi_at != EOI_NONE);
    end
  endtask

  task automatic random_frame();
    logic [31:0] lim;
    logic [31:0] len;
    logic [15:0] kind;
    int          pick;
    int          n;
    int          i;
    lim = (max_len < MAX_BODY) ? max_len : MAX_BODY;
    len = ($urandom_range(0, 7) == 0) ? 32'd0 : 32'($urandom_range(0, lim));
    kind = $urandom_range(KIND_FIRST, KIND_LAST);
    pick = $urandom_range(0, 99);
    if (pick >= 76 && pick < 82 && max_len == 32'hFFFF_FFFF) pick = 0;
    if (pick < 50) begin
      send_frame(magic_word, version, kind, len, len, 1'b1, 0,
                 $urandom_range(0, 1) ? EOI_LAST : EOI_NONE);
    end else if (pick < 58) begin
      send_frame(magic_word, version, kind, len, len, 1'b0, $urandom_range(0, 5), EOI_LAST);
    end else if (pick < 64) begin
      send_frame(magic_word ^ (32'h1 << $urandom_range(0, 31)), version, kind, len, len,
                 1'b1, $urandom_range(0, 4), EOI_LAST);
    end else if (pick < 70) begin
      send_frame(magic_word, version ^ (16'h1 << $urandom_range(0, 15)), kind, len, len,
                 1'b1, $urandom_range(0, 4), EOI_LAST);
    end else if (pick < 76) begin
      kind = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(5, 65535));
      send_frame(magic_word, version, kind, len, len, 1'b1, $urandom_range(0, 4), EOI_LAST);
    end else if (pick < 82) begin
      len = max_len + 1;
      if ($urandom_range(0, 1)) len = len + ($urandom % (~max_len));
      send_frame(magic_word, version, kind, len, $urandom_range(0, 6), 1'b1,
                 $urandom_range(0, 4), EOI_LAST);
    end else if (pick < 88) begin
      send_frame(magic_word, version, kind, len, len, 1'b1, 0, $urandom_range(0, 26));
    end else if (pick < 94) begin
      // end mark on the last header byte or inside the payload
      if (max_len == 0) len = 0;
      else if ($urandom_range(0, 3) == 0) len = max_len;
      else len = $urandom_range(1, lim);
      n = (len == 0) ? 0 : $urandom_range(0, (len - 1 > 40) ? 40 : len - 1);
      send_frame(magic_word, version, kind, len, n, 1'b1, 0, HDR_BYTES - 1 + n);
    end else begin
      n = $urandom_range(28, 60);
      for (i = 0; i < n; i++) queue_byte($urandom, i == n - 1);
    end
  endtask

  task automatic fill_random(input int target);
    int start;
    start = queued_total;
    while (queued_total - start < target) random_frame();
  endtask

  // sender holds off until every result has come back
  task automatic settle(input int extra);
    while (stream_bytes.size() != 0 || byte_valid || frame_outputs.size() != 0)
      @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MAX_PAYLOAD: max_len = val;
      REG_MAGIC:       magic_word = val;
      REG_VERSION:     version = val[15:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [31:0] mx, input logic [31:0] mg,
                              input logic [15:0] ver);
    write_reg(REG_MAX_PAYLOAD, mx);
    write_reg(REG_MAGIC, mg);
    write_reg(REG_VERSION, {16'd0, ver});
  endtask

  initial begin
    int seg;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed frames under the reset register values
    send_frame(32'd0, 16'd1, 16'd1, 32'd5, 0, 1'b1, 0, 0);
    send_frame(32'd0, 16'd1, 16'd1, 32'd5, 0, 1'b1, 0, 26);
    send_frame(32'd0, 16'd1, 16'd2, 32'd0, 0, 1'b1, 0, EOI_NONE);
    send_frame(32'd0, 16'd1, 16'd3, 32'd0, 0, 1'b0, 0, EOI_LAST);
    send_frame(32'd0, 16'd1, 16'd4, 32'd1, 1, 1'b1, 0, EOI_LAST);
    send_frame(32'd0, 16'd1, 16'd1, 32'd3, 3, 1'b1, 0, EOI_NONE);
    send_frame(32'd1, 16'd1, 16'd1, 32'd2, 2, 1'b1, 2, EOI_LAST);
    send_frame(32'd0, 16'd2, 16'd1, 32'd0, 0, 1'b1, 0, EOI_LAST);
    send_frame(32'd0, 16'd1, 16'd0, 32'd4, 4, 1'b1, 1, EOI_LAST);
    send_frame(32'd0, 16'd1, 16'd5, 32'd1, 1, 1'b1, 0, EOI_LAST);
    send_frame(32'd0, 16'd1, 16'hFFFF, 32'd1, 1, 1'b1, 0, EOI_LAST);
    send_frame(32'd0, 16'd1, 16'd1, 32'd65536, 3, 1'b1, 0, EOI_LAST);
    send_frame(32'd0, 16'd1, 16'd2, 32'd65535, 0, 1'b1, 0, HDR_BYTES - 1);
    send_frame(32'd0, 16'd1, 16'd3, 32'd6, 3, 1'b1, 0, HDR_BYTES + 2);
    send_frame(32'd0, 16'd1, 16'd4, 32'd2, 2, 1'b0, 3, EOI_LAST);
    send_frame(32'd0, 16'd1, 16'd2, 32'd2, 2, 1'b0, 0, EOI_LAST);

    for (seg = 0; seg < 6; seg++) begin
      sender_idle_pct   = (seg < 2) ? 34 : (seg < 4) ? 54 : 0;
      receiver_idle_pct = (seg < 2) ? 54 : (seg < 4) ? 34 : 0;
      settle(SETTLE);
      case (seg)
        0: begin
          apply_config(32'd0, 32'hFFFF_FFFF, 16'hFFFF);
          write_reg(REG_UNUSED, $urandom);
        end
        1: apply_config(32'hFFFF_FFFF, $urandom, $urandom);
        2: apply_config($urandom_range(0, 40), 32'd0, 16'd0);
        3: apply_config($urandom_range(1, 64), $urandom, $urandom);
        4: apply_config(RST_MAX_PAYLOAD, $urandom, $urandom);
        default: apply_config($urandom, $urandom, $urandom);
      endcase
      fill_random(SEG_BYTES / 2);
      settle(0);
      fill_random(SEG_BYTES / 2);
    end

    settle(SETTLE);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/fdc_pkg.sv
rtl/fdc_cfg_regs.sv
rtl/fdc_in_stage.sv
rtl/fdc_engine.sv
rtl/fdc_out_stage.sv
rtl/frame_deframer_checker_top.sv
rtl/fdc_checker.sv
bench/frame_deframer_checker_top_tb.sv
